// File: src/lwbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared constants and types of the LRU write-back cache.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  localparam int WAYS_DEF     = 8;
  localparam int KEY_BITS_DEF = 8;
  localparam int DATA_W       = 32;
  localparam int KEY_FIELD_W  = 8;
  localparam int CAP_W        = 4;
  localparam int IN_W         = KEY_FIELD_W + DATA_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(8);
  localparam logic             MODE_READ  = 1'b0;
  localparam logic             MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } lwbc_state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_PROMOTE,
    UPD_INSERT
  } lwbc_upd_e;

  typedef struct packed {
    logic hit;
    logic evict;
    logic vic_dirty;
  } lwbc_look_t;

  typedef struct packed {
    lwbc_upd_e op;
    logic      set_dirty;
    logic      evict;
  } lwbc_upd_t;

endpackage

// File: src/lwbc_data_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_data_ram
// Entry data store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lwbc_data_ram #(
  parameter int  WAYS = lwbc_pkg::WAYS_DEF,
  localparam int IW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IW-1:0]             waddr_i,
  input  logic [lwbc_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [IW-1:0]             raddr_i,
  output logic [lwbc_pkg::DATA_W-1:0] rdata_o
);
  import lwbc_pkg::*;

  logic [DATA_W-1:0] mem [WAYS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/lwbc_backing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_backing
// Backing memory; after reset a sweep loads every word with its own address.
// ----------------------------------------------------------------------------
module lwbc_backing #(
  parameter int KEY_BITS = lwbc_pkg::KEY_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [KEY_BITS-1:0]         waddr_i,
  input  logic [lwbc_pkg::DATA_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [KEY_BITS-1:0]         raddr_i,
  output logic [lwbc_pkg::DATA_W-1:0] rdata_o,
  output logic                        busy_o
);
  import lwbc_pkg::*;

  localparam int MEM_WORDS = 1 << KEY_BITS;

  logic [DATA_W-1:0]   mem [MEM_WORDS];
  logic [KEY_BITS-1:0] clr_addr_q;
  logic                busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= DATA_W'(clr_addr_q);
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

  assign busy_o = busy_q;

endmodule

// File: src/lwbc_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_tags
// Tag, valid, dirty and age store: key match, victim pick, LRU age update.
// ----------------------------------------------------------------------------
module lwbc_tags #(
  parameter int  WAYS     = lwbc_pkg::WAYS_DEF,
  parameter int  KEY_BITS = lwbc_pkg::KEY_BITS_DEF,
  localparam int IW       = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int CW       = $clog2(WAYS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [CW-1:0]       cap_i,
  output lwbc_pkg::lwbc_look_t look_o,
  output logic [IW-1:0]       way_o,
  output logic [KEY_BITS-1:0] vic_key_o,
  input  lwbc_pkg::lwbc_upd_t upd_i,
  input  logic [IW-1:0]       upd_way_i,
  input  logic [KEY_BITS-1:0] upd_key_i
);
  import lwbc_pkg::*;

  logic [KEY_BITS-1:0] key_q [WAYS];
  logic [IW-1:0]       age_q [WAYS];
  logic [WAYS-1:0]     valid_q;
  logic [WAYS-1:0]     dirty_q;
  logic [CW-1:0]       count_q;

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] oldest;
  logic [CW-1:0]   cnt_m1;
  logic [IW-1:0]   hit_idx;
  logic [IW-1:0]   vic_idx;
  logic [IW-1:0]   free_idx;
  logic [IW-1:0]   age_w;

  // valid entries hold distinct ages 0..count-1, so the victim has age count-1
  always_comb begin
    cnt_m1   = count_q - CW'(1);
    hit_idx  = '0;
    vic_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == key_i);
      oldest[i] = valid_q[i] && (CW'(age_q[i]) == cnt_m1);
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
      if (oldest[i]) begin
        vic_idx = vic_idx | IW'(i);
      end
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
    end
    look_o.hit       = |match;
    look_o.evict     = !(|match) && (count_q >= cap_i);
    look_o.vic_dirty = dirty_q[vic_idx];
    vic_key_o        = key_q[vic_idx];
    if (look_o.hit) begin
      way_o = hit_idx;
    end else if (look_o.evict) begin
      way_o = vic_idx;
    end else begin
      way_o = free_idx;
    end
  end

  assign age_w = age_q[upd_way_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      count_q <= '0;
      for (int i = 0; i < WAYS; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      unique case (upd_i.op)
        UPD_PROMOTE: begin
          for (int i = 0; i < WAYS; i++) begin
            if (valid_q[i] && (IW'(i) != upd_way_i) && (age_q[i] < age_w)) begin
              age_q[i] <= age_q[i] + 1'b1;
            end
          end
          age_q[upd_way_i] <= '0;
          if (upd_i.set_dirty) begin
            dirty_q[upd_way_i] <= 1'b1;
          end
        end
        UPD_INSERT: begin
          for (int i = 0; i < WAYS; i++) begin
            if (valid_q[i] && (IW'(i) != upd_way_i)) begin
              age_q[i] <= age_q[i] + 1'b1;
            end
          end
          age_q[upd_way_i]   <= '0;
          valid_q[upd_way_i] <= 1'b1;
          dirty_q[upd_way_i] <= upd_i.set_dirty;
          if (!upd_i.evict) begin
            count_q <= count_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.op == UPD_INSERT) begin
      key_q[upd_way_i] <= upd_key_i;
    end
  end

endmodule

// File: src/lru_write_back_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_write_back_cache
// Fully associative write-back cache with LRU replacement over a backing RAM.
// ----------------------------------------------------------------------------
// Input words on s_axis: tuser is the mode (read or write), tdata the key and
// the write value. Each input word gives exactly one output word on m_axis:
// tuser is the hit flag, tdata the read value (the written value on a write).
// cfg_we_i/cfg_wdata_i set the number of cache entries in use; zero sends
// every access straight to the backing memory. Write it only while idle.
// An item goes through accept, tag lookup with RAM reads issued, then the
// read-modify-write of tags, entry data and backing memory. The registered
// read ports of the two RAMs set this; one item is in flight at a time, so
// a new word is taken only once the previous one has left its last step.
// The result sits in an output register; the next word can be accepted while
// it waits. If the receiver stalls, the following item holds in its last
// step until the output register frees up.
// After reset the backing memory is swept so each word holds its address:
// s_axis_tready is low until all 2^KEY_BITS words (256 by default) are set.
// Capacity resets to 8, and the cache starts empty.
// ----------------------------------------------------------------------------
module lru_write_back_cache #(
  parameter int  WAYS     = lwbc_pkg::WAYS_DEF,
  parameter int  KEY_BITS = lwbc_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lwbc_pkg::IN_W-1:0]    s_axis_tdata,   // key[7:0], wdata[39:8]
  input  logic                         s_axis_tuser,   // mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lwbc_pkg::DATA_W-1:0]  m_axis_tdata,   // rdata[31:0]
  output logic                         m_axis_tuser,   // hit
  input  logic                         cfg_we_i,
  input  logic [lwbc_pkg::CAP_W-1:0]   cfg_wdata_i     // capacity
);
  import lwbc_pkg::*;

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  lwbc_state_e state_q, state_d;

  logic [CAP_W-1:0]    cap_q;
  logic [CW-1:0]       cap_eff;
  logic                mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [DATA_W-1:0]   wdata_q;
  logic                hit_q;
  logic                evict_q;
  logic                wb_q;
  logic                byp_q;
  logic [IW-1:0]       way_q;
  logic [KEY_BITS-1:0] vic_key_q;

  logic                out_valid_q;
  logic                out_hit_q;
  logic [DATA_W-1:0]   out_rdata_q;

  logic                accept;
  logic                fire;
  logic                res_hit;
  logic [DATA_W-1:0]   res_rdata;

  lwbc_look_t          look;
  logic [IW-1:0]       look_way;
  logic [KEY_BITS-1:0] look_vic_key;
  lwbc_upd_t           upd;

  logic                dram_we;
  logic [DATA_W-1:0]   dram_wdata;
  logic                dram_re;
  logic [DATA_W-1:0]   dram_rdata;

  logic                bmem_we;
  logic [KEY_BITS-1:0] bmem_waddr;
  logic [DATA_W-1:0]   bmem_wdata;
  logic                bmem_re;
  logic [DATA_W-1:0]   bmem_rdata;
  logic                bmem_busy;

  assign cap_eff = (int'(cap_q) > WAYS) ? CW'(WAYS) : CW'(cap_q);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign fire    = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  lwbc_tags #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_tags (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (key_q),
    .cap_i     (cap_eff),
    .look_o    (look),
    .way_o     (look_way),
    .vic_key_o (look_vic_key),
    .upd_i     (upd),
    .upd_way_i (way_q),
    .upd_key_i (key_q)
  );

  lwbc_data_ram #(
    .WAYS (WAYS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (way_q),
    .wdata_i (dram_wdata),
    .re_i    (dram_re),
    .raddr_i (look_way),
    .rdata_o (dram_rdata)
  );

  lwbc_backing #(
    .KEY_BITS (KEY_BITS)
  ) u_backing (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (bmem_we),
    .waddr_i (bmem_waddr),
    .wdata_i (bmem_wdata),
    .re_i    (bmem_re),
    .raddr_i (key_q),
    .rdata_o (bmem_rdata),
    .busy_o  (bmem_busy)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_EXEC;
      ST_EXEC: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) && !bmem_busy;
    dram_re       = (state_q == ST_LOOK);
    bmem_re       = (state_q == ST_LOOK);

    dram_we       = 1'b0;
    dram_wdata    = (mode_q == MODE_WRITE) ? wdata_q : bmem_rdata;
    bmem_we       = 1'b0;
    bmem_waddr    = key_q;
    bmem_wdata    = wdata_q;
    upd.op        = UPD_NONE;
    upd.set_dirty = (mode_q == MODE_WRITE);
    upd.evict     = evict_q;
    res_hit       = !byp_q && hit_q;

    if (mode_q == MODE_WRITE) begin
      res_rdata = wdata_q;
    end else if (!byp_q && hit_q) begin
      res_rdata = dram_rdata;
    end else begin
      res_rdata = bmem_rdata;
    end

    if (fire) begin
      if (byp_q) begin
        bmem_we = (mode_q == MODE_WRITE);
      end else if (hit_q) begin
        upd.op  = UPD_PROMOTE;
        dram_we = (mode_q == MODE_WRITE);
      end else begin
        upd.op     = UPD_INSERT;
        dram_we    = 1'b1;
        bmem_we    = wb_q;
        bmem_waddr = vic_key_q;
        bmem_wdata = dram_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= s_axis_tuser;
      key_q   <= KEY_BITS'(s_axis_tdata[KEY_FIELD_W-1:0]);
      wdata_q <= s_axis_tdata[IN_W-1:KEY_FIELD_W];
    end
    if (state_q == ST_LOOK) begin
      hit_q     <= look.hit;
      evict_q   <= look.evict;
      wb_q      <= look.evict && look.vic_dirty;
      byp_q     <= (cap_q == '0);
      way_q     <= look_way;
      vic_key_q <= look_vic_key;
    end
    if (fire) begin
      out_hit_q   <= res_hit;
      out_rdata_q <= res_rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rdata_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

// File: src/lwbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbc_checker
// Port-level checks of the LRU write-back cache, bound to the top level.
// ----------------------------------------------------------------------------
module lwbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [lwbc_pkg::IN_W-1:0]   s_axis_tdata,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [lwbc_pkg::DATA_W-1:0] m_axis_tdata
);
  import lwbc_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second word accepted while one is in flight");

  a_write_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == MODE_WRITE) && !m_axis_tvalid |-> ##3
      (m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata[IN_W-1:KEY_FIELD_W], 3))))
    else $error("write did not return its value");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while input side was idle");

endmodule

bind lru_write_back_cache lwbc_checker u_lwbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU write-back cache. Directed accesses cover
// empty-cache misses, dirty evictions, bypass mode and capacity changes. They
// are followed by random traffic, mostly on small key sets, under several
// capacity settings and three idle patterns. Output words are checked against
// the directed table or a bench shadow of the cache and backing memory.
// ----------------------------------------------------------------------------
module tb_top;
  import lwbc_pkg::*;

  localparam int NWAYS       = WAYS_DEF;
  localparam int MEM_DEPTH   = 1 << KEY_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_WORDS   = 39;
  localparam int SEGS        = 6;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] rdata;
  } access_res_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CAP_W-1:0]       cap;
    logic                   mode;
    logic [KEY_FIELD_W-1:0] key;
    logic [DATA_W-1:0]      wdata;
    logic                   typed;
    logic                   hit;
    logic [DATA_W-1:0]      rdata;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata  = '0;
  logic                   s_axis_tuser  = MODE_READ;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_W-1:0]      m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata_i   = CAP_RESET;

  // shadow cache state
  logic [KEY_FIELD_W-1:0] sh_key   [NWAYS];
  logic                   sh_valid [NWAYS];
  logic [DATA_W-1:0]      sh_data  [NWAYS];
  logic                   sh_dirty [NWAYS];
  int unsigned            sh_age   [NWAYS];
  logic [DATA_W-1:0]      sh_mem   [MEM_DEPTH];
  logic [CAP_W-1:0]       sh_cap;

  access_res_t            expected_q [$];
  int                     mismatches = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     stall_cycles;

  dir_row_t               dir_tab [25];
  logic [CAP_W-1:0]       cap_list [SEGS];

  lru_write_back_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // miss fill: evict the single oldest entry when full, then insert as newest
  function automatic void cache_fill(input logic [KEY_FIELD_W-1:0] key,
                                     input logic [DATA_W-1:0] val,
                                     input logic dirty, input int unsigned cap);
    int unsigned used;
    int victim;
    int slot;
    used = 0;
    for (int i = 0; i < NWAYS; i++) if (sh_valid[i]) used++;
    if (used >= cap) begin
      victim = -1;
      for (int i = 0; i < NWAYS; i++)
        if (sh_valid[i] && (victim < 0 || sh_age[i] > sh_age[victim])) victim = i;
      if (victim >= 0) begin
        if (sh_dirty[victim]) sh_mem[sh_key[victim]] = sh_data[victim];
        sh_valid[victim] = 1'b0;
        sh_dirty[victim] = 1'b0;
      end
    end
    slot = -1;
    for (int i = 0; i < NWAYS; i++) if (!sh_valid[i] && slot < 0) slot = i;
    if (slot < 0) return;
    for (int i = 0; i < NWAYS; i++) if (sh_valid[i]) sh_age[i]++;
    sh_valid[slot] = 1'b1;
    sh_key[slot]   = key;
    sh_data[slot]  = val;
    sh_dirty[slot] = dirty;
    sh_age[slot]   = 0;
  endfunction

  function automatic access_res_t cache_access(input logic mode,
                                               input logic [KEY_FIELD_W-1:0] key,
                                               input logic [DATA_W-1:0] wd);
    access_res_t r;
    int unsigned cap;
    int w;
    int unsigned a;
    cap = (sh_cap > NWAYS) ? NWAYS : sh_cap;
    r.hit = 1'b0;
    if (cap == 0) begin
      if (mode == MODE_WRITE) begin
        sh_mem[key] = wd;
        r.rdata = wd;
      end else begin
        r.rdata = sh_mem[key];
      end
    end else begin
      w = -1;
      for (int i = 0; i < NWAYS; i++)
        if (w < 0 && sh_valid[i] && sh_key[i] == key) w = i;
      if (w >= 0) begin
        r.hit = 1'b1;
        a = sh_age[w];
        for (int i = 0; i < NWAYS; i++)
          if (sh_valid[i] && i != w && sh_age[i] < a) sh_age[i]++;
        sh_age[w] = 0;
        if (mode == MODE_WRITE) begin
          sh_data[w]  = wd;
          sh_dirty[w] = 1'b1;
        end
        r.rdata = sh_data[w];
      end else if (mode == MODE_WRITE) begin
        cache_fill(key, wd, 1'b1, cap);
        r.rdata = wd;
      end else begin
        r.rdata = sh_mem[key];
        cache_fill(key, r.rdata, 1'b0, cap);
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic mode, input logic [KEY_FIELD_W-1:0] key,
                           input logic [DATA_W-1:0] wd, output access_res_t pred);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {wd, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = cache_access(mode, key, wd);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_cap = cap;
  endtask

  // output checker and receiver back-pressure
  always @(posedge clk_i) begin
    access_res_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: hit %0d rdata %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        exp_w = expected_q.pop_front();
        if (m_axis_tuser !== exp_w.hit || m_axis_tdata !== exp_w.rdata) begin
          if (mismatches < 10)
            $display("mismatch: hit exp %0d got %0d, rdata exp %h got %h",
                     exp_w.hit, m_axis_tuser, exp_w.rdata, m_axis_tdata);
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("lru_write_back_cache test failed");
    $finish;
  end

  initial begin
    access_res_t pred;
    int unsigned cap_eff;
    int unsigned pick;
    logic [KEY_FIELD_W-1:0] key;
    logic mode;

    for (int a = 0; a < MEM_DEPTH; a++) sh_mem[a] = DATA_W'(a);
    for (int i = 0; i < NWAYS; i++) begin
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_age[i]   = 0;
      sh_key[i]   = '0;
      sh_data[i]  = '0;
    end
    sh_cap = CAP_RESET;

    dir_tab = '{
      '{1'b0, 4'd0,  MODE_READ,  8'd0,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_READ,  8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_00FF},
      '{1'b0, 4'd0,  MODE_WRITE, 8'd5,   32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000},
      '{1'b0, 4'd0,  MODE_READ,  8'd5,   32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{1'b0, 4'd0,  MODE_WRITE, 8'd255, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{1'b0, 4'd0,  MODE_WRITE, 8'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{1'b0, 4'd0,  MODE_READ,  8'd1,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0001},
      '{1'b0, 4'd0,  MODE_READ,  8'd2,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0002},
      '{1'b0, 4'd0,  MODE_READ,  8'd3,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0003},
      '{1'b0, 4'd0,  MODE_READ,  8'd4,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0004},
      '{1'b0, 4'd0,  MODE_READ,  8'd6,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0006},
      // full: evicts dirty key 5
      '{1'b0, 4'd0,  MODE_READ,  8'd7,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0007},
      '{1'b0, 4'd0,  MODE_READ,  8'd5,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      // bypass: stale dirty entry for key 0 stays cached
      '{1'b1, 4'd0,  MODE_READ,  8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_READ,  8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_WRITE, 8'd9,   32'h1234_5678, 1'b1, 1'b0, 32'h1234_5678},
      '{1'b0, 4'd0,  MODE_READ,  8'd9,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      // capacity below occupancy
      '{1'b1, 4'd1,  MODE_READ,  8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_READ,  8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_READ,  8'd200, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_WRITE, 8'd200, 32'hAAAA_5555, 1'b0, 1'b0, 32'h0000_0000},
      // above WAYS clamps to WAYS
      '{1'b1, 4'd15, MODE_READ,  8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_WRITE, 8'd10,  32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 4'd0,  MODE_READ,  8'd10,  32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b1, 4'd8,  MODE_READ,  8'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
    };
    cap_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd5};

    send_idle_pct = 38;
    recv_idle_pct = 86;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_capacity(CAP_RESET);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        set_capacity(dir_tab[r].cap);
      end else begin
        send_word(dir_tab[r].mode, dir_tab[r].key, dir_tab[r].wdata, pred);
        if (dir_tab[r].typed)
          expected_q.push_back('{dir_tab[r].hit, dir_tab[r].rdata});
        else
          expected_q.push_back(pred);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SEGS; s++) begin
        set_capacity(cap_list[(s + 2 * ph) % SEGS]);
        cap_eff = (sh_cap > NWAYS) ? NWAYS : sh_cap;
        for (int n = 0; n < SEG_WORDS; n++) begin
          if (ph == 1 && s == 2 && n == SEG_WORDS / 2) wait_drained();
          pick = $urandom_range(99);
          if (pick < 75)
            key = KEY_FIELD_W'($urandom_range(cap_eff + 4));
          else if (pick < 90)
            key = KEY_FIELD_W'($urandom_range(15));
          else
            key = KEY_FIELD_W'($urandom_range(MEM_DEPTH - 1));
          mode = ($urandom_range(1) == 1) ? MODE_WRITE : MODE_READ;
          send_word(mode, key, DATA_W'($urandom), pred);
          expected_q.push_back(pred);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("lru_write_back_cache test passed");
    end else begin
      $display("lru_write_back_cache test failed");
    end
    $finish;
  end

endmodule
